>>> hw/rtl/set_assoc_lru_cache_sim_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the set-associative LRU cache model
// Shared property forms, clocked on clk and disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef SET_ASSOC_LRU_CACHE_SIM_ASSERT_SVH
`define SET_ASSOC_LRU_CACHE_SIM_ASSERT_SVH

// same-cycle implication
`define SLC_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("slc assertion failed");

// next-cycle implication
`define SLC_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("slc assertion failed");

`endif

>>> hw/rtl/slc_pkg.sv
// ----------------------------------------------------------------------------
// slc_pkg
// Types and constants shared by the set-associative LRU cache model.
// ----------------------------------------------------------------------------
package slc_pkg;

	// access modes
	localparam logic [1:0] MODE_LOAD   = 2'd0;
	localparam logic [1:0] MODE_STORE  = 2'd1;
	localparam logic [1:0] MODE_MODIFY = 2'd2;
	localparam logic [1:0] MODE_IFETCH = 2'd3;

	// configuration register indexes
	localparam logic [1:0] CFG_SET_BITS   = 2'd0;
	localparam logic [1:0] CFG_BLOCK_BITS = 2'd1;
	localparam logic [1:0] CFG_WAYS_USED  = 2'd2;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 5;
	localparam int SHIFT_W    = 6;

	typedef struct packed {
		logic [1:0]  mode;
		logic [63:0] address;
	} acc_t;

	typedef struct packed {
		logic        hit;
		logic        miss;
		logic        eviction;
		logic        extra_hit;
		logic [31:0] hit_total;
		logic [31:0] miss_total;
		logic [31:0] eviction_total;
	} res_t;

	// one cache line as held in a memory row
	typedef struct packed {
		logic        valid;
		logic [63:0] tag;
		logic [31:0] stamp;
	} way_t;

	typedef enum logic [1:0] {
		LK_HIT,
		LK_FILL,
		LK_EVICT
	} lk_kind_t;

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_LOOKUP
	} cache_state_t;

	function automatic logic [31:0] sat_inc(input logic [31:0] v);
		return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
	endfunction

endpackage

>>> hw/rtl/slc_lookup.sv
// ----------------------------------------------------------------------------
// slc_lookup
// Compares all ways of one set row and picks the target way: the first
// matching valid way, else the first invalid way, else the oldest stamp.
// ----------------------------------------------------------------------------
module slc_lookup #(
	parameter int MAX_WAYS = 8
) (
	input  slc_pkg::way_t [MAX_WAYS-1:0]           row,
	input  logic [63:0]                            tag,
	input  logic [$clog2(MAX_WAYS+1)-1:0]          ways_eff,
	output slc_pkg::lk_kind_t                      kind,
	output logic [((MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1)-1:0] target
);
	import slc_pkg::*;

	localparam int WAY_AW = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
	localparam int LVL    = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 0;
	localparam int W2     = 1 << LVL;

	logic              found;
	logic              has_empty;
	logic [WAY_AW-1:0] hit_way;
	logic [WAY_AW-1:0] empty_way;

	logic              t_cand  [0:LVL][0:W2-1];
	logic [31:0]       t_stamp [0:LVL][0:W2-1];
	logic [WAY_AW-1:0] t_idx   [0:LVL][0:W2-1];

	// first match and first empty way; scan downward so the lowest way wins
	always_comb begin
		found     = 1'b0;
		has_empty = 1'b0;
		hit_way   = '0;
		empty_way = '0;
		for (int w = MAX_WAYS - 1; w >= 0; w--) begin
			if (w < int'(ways_eff)) begin
				if (row[w].valid && row[w].tag == tag) begin
					found   = 1'b1;
					hit_way = WAY_AW'(w);
				end
				if (!row[w].valid) begin
					has_empty = 1'b1;
					empty_way = WAY_AW'(w);
				end
			end
		end
	end

	// minimum-stamp tree; ties keep the lower way
	always_comb begin
		for (int l = 0; l <= LVL; l++) begin
			for (int n = 0; n < W2; n++) begin
				t_cand[l][n]  = 1'b0;
				t_stamp[l][n] = '0;
				t_idx[l][n]   = '0;
			end
		end
		for (int w = 0; w < W2; w++) begin
			if (w < MAX_WAYS) begin
				t_cand[0][w]  = (w < int'(ways_eff));
				t_stamp[0][w] = row[w].stamp;
				t_idx[0][w]   = WAY_AW'(w);
			end
		end
		for (int l = 0; l < LVL; l++) begin
			for (int n = 0; n < (W2 >> (l + 1)); n++) begin
				if (t_cand[l][2*n+1] && (!t_cand[l][2*n] ||
						t_stamp[l][2*n+1] < t_stamp[l][2*n])) begin
					t_cand[l+1][n]  = 1'b1;
					t_stamp[l+1][n] = t_stamp[l][2*n+1];
					t_idx[l+1][n]   = t_idx[l][2*n+1];
				end else begin
					t_cand[l+1][n]  = t_cand[l][2*n];
					t_stamp[l+1][n] = t_stamp[l][2*n];
					t_idx[l+1][n]   = t_idx[l][2*n];
				end
			end
		end
	end

	always_comb begin
		if (found) begin
			kind   = LK_HIT;
			target = hit_way;
		end else if (has_empty) begin
			kind   = LK_FILL;
			target = empty_way;
		end else begin
			kind   = LK_EVICT;
			target = t_idx[LVL][0];
		end
	end

endmodule

>>> hw/rtl/set_assoc_lru_cache_sim.sv
// ----------------------------------------------------------------------------
// set_assoc_lru_cache_sim
// Set-associative cache model with least-recently-used replacement.
// ----------------------------------------------------------------------------
// An access is taken into the lookup state: the accepting edge reads the set's
// row from the row memory, and the lookup edge compares all ways, writes the row
// back and loads the result register. A result that is stalled holds the lookup
// state, so the next access waits until the result register is free. After reset
// the block clears the row memory, one set per cycle, all 2**MAX_SET_BITS sets
// (64 by default), before it takes its first access; configuration writes are
// taken at any time. Instruction fetches pass through the same two steps and
// leave the cache untouched.
// ----------------------------------------------------------------------------
module set_assoc_lru_cache_sim #(
	parameter int MAX_SET_BITS = 6,
	parameter int MAX_WAYS     = 8
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               acc_valid,
	output logic                               acc_stall,
	input  slc_pkg::acc_t                      acc,
	output logic                               res_valid,
	input  logic                               res_stall,
	output slc_pkg::res_t                      res,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [slc_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [slc_pkg::CFG_DATA_W-1:0]     cfg_data
);
	import slc_pkg::*;

	localparam int SETS   = 1 << MAX_SET_BITS;
	localparam int SET_AW = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
	localparam int WAY_AW = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
	localparam int WAY_CW = $clog2(MAX_WAYS + 1);

	typedef way_t [MAX_WAYS-1:0] row_t;

	row_t row_mem [SETS];

	cache_state_t state_q, state_d;

	logic [2:0]        set_bits_q;
	logic [4:0]        block_bits_q;
	logic [3:0]        ways_used_q;
	logic [SET_AW-1:0] clr_idx_q;
	logic [31:0]       access_q;
	logic [31:0]       hits_q;
	logic [31:0]       misses_q;
	logic [31:0]       evicts_q;
	logic              res_valid_q;
	res_t              res_q;

	logic [SET_AW-1:0] set_s1;
	logic [63:0]       tag_s1;
	logic [1:0]        mode_s1;
	row_t              rd_row_q;

	logic [SHIFT_W-1:0] sb_eff;
	logic [WAY_CW-1:0]  ways_eff;
	logic [63:0]        addr_shift;
	logic [SET_AW-1:0]  set_mask;
	logic [SET_AW-1:0]  set_idx;
	logic [63:0]        tag_in;

	logic              acc_take;
	logic              lookup_fire;
	logic              clear_we;
	logic              clear_last;
	logic              mem_we;
	logic [SET_AW-1:0] mem_wa;
	row_t              mem_wd;
	row_t              wb_row;

	lk_kind_t          kind;
	logic [WAY_AW-1:0] target;
	logic              is_fetch;
	logic [31:0]       hits_one;
	logic [31:0]       hits_nx;
	logic [31:0]       misses_nx;
	logic [31:0]       evicts_nx;

	// ---------------- configuration ----------------
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			set_bits_q   <= '0;
			block_bits_q <= '0;
			ways_used_q  <= 4'd1;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_SET_BITS:   set_bits_q   <= cfg_data[2:0];
				CFG_BLOCK_BITS: block_bits_q <= cfg_data[4:0];
				CFG_WAYS_USED:  ways_used_q  <= cfg_data[3:0];
				default: ;
			endcase
		end
	end

	// clamp the registers to what the storage supports
	always_comb begin
		if (int'(set_bits_q) > MAX_SET_BITS) begin
			sb_eff = SHIFT_W'(MAX_SET_BITS);
		end else begin
			sb_eff = SHIFT_W'(set_bits_q);
		end
		if (ways_used_q == 4'd0) begin
			ways_eff = WAY_CW'(1);
		end else if (int'(ways_used_q) > MAX_WAYS) begin
			ways_eff = WAY_CW'(MAX_WAYS);
		end else begin
			ways_eff = WAY_CW'(ways_used_q);
		end
	end

	// ---------------- address split ----------------
	always_comb begin
		addr_shift = acc.address >> block_bits_q;
		set_mask   = ~({SET_AW{1'b1}} << sb_eff);
		set_idx    = addr_shift[SET_AW-1:0] & set_mask;
		tag_in     = acc.address >> (sb_eff + SHIFT_W'(block_bits_q));
	end

	// ---------------- control ----------------
	assign clear_last = (clr_idx_q == SET_AW'(SETS - 1));

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLEAR:  if (clear_last) state_d = ST_IDLE;
			ST_IDLE:   if (acc_valid) state_d = ST_LOOKUP;
			ST_LOOKUP: if (!res_valid_q || !res_stall) state_d = ST_IDLE;
			default:   state_d = ST_CLEAR;
		endcase
	end

	always_comb begin
		acc_stall   = 1'b1;
		clear_we    = 1'b0;
		lookup_fire = 1'b0;
		case (state_q)
			ST_CLEAR:  clear_we = 1'b1;
			ST_IDLE:   acc_stall = 1'b0;
			ST_LOOKUP: lookup_fire = !res_valid_q || !res_stall;
			default: ;
		endcase
	end

	assign acc_take = acc_valid && !acc_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_CLEAR;
			clr_idx_q <= '0;
		end else begin
			state_q <= state_d;
			if (clear_we) clr_idx_q <= clr_idx_q + SET_AW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (acc_take) begin
			set_s1  <= set_idx;
			tag_s1  <= tag_in;
			mode_s1 <= acc.mode;
		end
	end

	// ---------------- row memory ----------------
	always_ff @(posedge clk) begin
		if (mem_we) row_mem[mem_wa] <= mem_wd;
		if (acc_take) rd_row_q <= row_mem[set_idx];
	end

	slc_lookup #(
		.MAX_WAYS(MAX_WAYS)
	) u_lookup (
		.row     (rd_row_q),
		.tag     (tag_s1),
		.ways_eff(ways_eff),
		.kind    (kind),
		.target  (target)
	);

	assign is_fetch = (mode_s1 == MODE_IFETCH);

	// refresh the used way; a miss also installs the new tag
	always_comb begin
		wb_row                = rd_row_q;
		wb_row[target].stamp  = access_q;
		if (kind != LK_HIT) begin
			wb_row[target].valid = 1'b1;
			wb_row[target].tag   = tag_s1;
		end
	end

	always_comb begin
		if (clear_we) begin
			mem_we = 1'b1;
			mem_wa = clr_idx_q;
			mem_wd = '0;
		end else begin
			mem_we = lookup_fire && !is_fetch;
			mem_wa = set_s1;
			mem_wd = wb_row;
		end
	end

	// ---------------- totals and result ----------------
	always_comb begin
		hits_one  = (kind == LK_HIT) ? sat_inc(hits_q) : hits_q;
		hits_nx   = (mode_s1 == MODE_MODIFY) ? sat_inc(hits_one) : hits_one;
		misses_nx = (kind != LK_HIT) ? sat_inc(misses_q) : misses_q;
		evicts_nx = (kind == LK_EVICT) ? sat_inc(evicts_q) : evicts_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			access_q    <= '0;
			hits_q      <= '0;
			misses_q    <= '0;
			evicts_q    <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (lookup_fire) begin
				res_valid_q <= 1'b1;
				if (!is_fetch) begin
					access_q <= access_q + 32'd1;
					hits_q   <= hits_nx;
					misses_q <= misses_nx;
					evicts_q <= evicts_nx;
				end
			end else if (!res_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (lookup_fire) begin
			if (is_fetch) begin
				res_q.hit            <= 1'b0;
				res_q.miss           <= 1'b0;
				res_q.eviction       <= 1'b0;
				res_q.extra_hit      <= 1'b0;
				res_q.hit_total      <= hits_q;
				res_q.miss_total     <= misses_q;
				res_q.eviction_total <= evicts_q;
			end else begin
				res_q.hit            <= (kind == LK_HIT);
				res_q.miss           <= (kind != LK_HIT);
				res_q.eviction       <= (kind == LK_EVICT);
				res_q.extra_hit      <= (mode_s1 == MODE_MODIFY);
				res_q.hit_total      <= hits_nx;
				res_q.miss_total     <= misses_nx;
				res_q.eviction_total <= evicts_nx;
			end
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

endmodule

>>> hw/rtl/slc_checker.sv
// ----------------------------------------------------------------------------
// slc_checker
// Port-level checks on the result channel of the cache model.
// ----------------------------------------------------------------------------
`include "set_assoc_lru_cache_sim_assert.svh"

module slc_checker (
	input logic          clk,
	input logic          arst_n,
	input logic          res_valid,
	input logic          res_stall,
	input slc_pkg::res_t res
);
	import slc_pkg::*;

	// an access is never both a hit and a miss, and only a miss evicts
	`SLC_ASSERT_NOW(a_hit_miss_excl, res_valid, !(res.hit && res.miss) && (!res.eviction || res.miss))

	// the extra hit of a modify only comes with a real lookup
	`SLC_ASSERT_NOW(a_extra_needs_lookup, res_valid && res.extra_hit, res.hit || res.miss)

	// hold a stalled transaction
	`SLC_ASSERT_NEXT(a_res_hold, res_valid && res_stall, res_valid && $stable(res))

endmodule

bind set_assoc_lru_cache_sim slc_checker u_slc_checker (.*);

>>> tb/tb_set_assoc_lru_cache_sim.sv
// ----------------------------------------------------------------------------
// tb_set_assoc_lru_cache_sim
// Self-checking bench for the set-associative LRU cache model. A directed
// table covers reset, the address extremes, every access mode and the register
// corner values. Random phases then run several cache geometries with reused
// tags, so that hits, fills and evictions all occur. Every result is compared
// field by field against a line-level cache model kept inside the bench.
// ----------------------------------------------------------------------------
module tb_set_assoc_lru_cache_sim;
	timeunit 1ns;
	timeprecision 1ps;

	import slc_pkg::*;

	localparam int SET_BITS_CAP   = 6;
	localparam int WAY_CAP        = 8;
	localparam int LINES          = (1 << SET_BITS_CAP) * WAY_CAP;
	localparam int HOLD_CYCLES    = 300;
	localparam int WATCHDOG_LIMIT = 3000;
	localparam int TAIL_CYCLES    = 8;
	localparam int DIR_ROWS       = 23;
	localparam int PHASES         = 6;

	// register index with no register behind it
	localparam logic [1:0] CFG_NO_REG = 2'd3;

	typedef enum bit {ROW_ACC, ROW_CFG} row_kind_t;

	typedef struct packed {
		row_kind_t   kind;
		logic [1:0]  mode;
		logic [63:0] address;
		logic [1:0]  reg_idx;
		logic [4:0]  reg_val;
		bit          typed;
		logic [3:0]  flags;    // hit, miss, eviction, extra_hit
	} stim_row_t;

	typedef struct packed {
		bit         typed;
		logic [3:0] flags;
	} row_mark_t;

	typedef struct packed {
		logic [4:0] sb_val;
		logic [4:0] bb_val;
		logic [4:0] ways_val;
		logic [7:0] items;
		logic [6:0] send_pct;
		logic [6:0] recv_pct;
		bit         pressure;
	} phase_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic acc_valid = 1'b0;
	logic acc_stall;
	acc_t acc = '0;
	logic res_valid;
	logic res_stall = 1'b0;
	res_t res;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	// bench copy of the cache
	logic [2:0]  geo_set_bits = 3'd0;
	logic [4:0]  geo_block_bits = 5'd0;
	logic [3:0]  geo_ways = 4'd1;
	bit          valid_mem [LINES];
	logic [63:0] tag_mem [LINES];
	logic [31:0] stamp_mem [LINES];
	logic [31:0] use_clock = '0;
	logic [31:0] hits_pred = '0;
	logic [31:0] misses_pred = '0;
	logic [31:0] evict_count = '0;

	res_t pending_results [$];
	row_mark_t row_marks [$];

	int unsigned send_idle_pct = 0;
	int unsigned recv_stall_pct = 0;
	int unsigned hold_ticket = 0;
	int unsigned hold_served = 0;
	int hold_left = 0;
	int stuck_cycles = 0;
	int mismatch_count = 0;
	int accesses_seen = 0;
	int results_seen = 0;
	int reg_writes = 0;

	stim_row_t dir_rows [DIR_ROWS] = '{
		'{ROW_ACC, MODE_LOAD,   64'h0,                   CFG_SET_BITS,   5'd0,  1'b1, 4'b0100},
		'{ROW_ACC, MODE_LOAD,   64'h0,                   CFG_SET_BITS,   5'd0,  1'b1, 4'b1000},
		'{ROW_ACC, MODE_MODIFY, 64'h0,                   CFG_SET_BITS,   5'd0,  1'b1, 4'b1001},
		'{ROW_ACC, MODE_IFETCH, 64'hFFFF_FFFF_FFFF_FFFF, CFG_SET_BITS,   5'd0,  1'b1, 4'b0000},
		'{ROW_ACC, MODE_STORE,  64'h1,                   CFG_SET_BITS,   5'd0,  1'b1, 4'b0110},
		'{ROW_ACC, MODE_MODIFY, 64'hFFFF_FFFF_FFFF_FFFF, CFG_SET_BITS,   5'd0,  1'b1, 4'b0111},
		'{ROW_ACC, MODE_LOAD,   64'hFFFF_FFFF_FFFF_FFFF, CFG_SET_BITS,   5'd0,  1'b1, 4'b1000},
		'{ROW_ACC, MODE_IFETCH, 64'h0,                   CFG_SET_BITS,   5'd0,  1'b1, 4'b0000},
		'{ROW_CFG, MODE_LOAD,   64'h0,                   CFG_WAYS_USED,  5'd2,  1'b0, 4'b0000},
		'{ROW_CFG, MODE_LOAD,   64'h0,                   CFG_BLOCK_BITS, 5'd4,  1'b0, 4'b0000},
		'{ROW_ACC, MODE_LOAD,   64'h10,                  CFG_SET_BITS,   5'd0,  1'b0, 4'b0000},
		'{ROW_ACC, MODE_STORE,  64'h20,                  CFG_SET_BITS,   5'd0,  1'b0, 4'b0000},
		'{ROW_ACC, MODE_LOAD,   64'h10,                  CFG_SET_BITS,   5'd0,  1'b0, 4'b0000},
		// set count above the cap
		'{ROW_CFG, MODE_LOAD,   64'h0,                   CFG_SET_BITS,   5'd7,  1'b0, 4'b0000},
		'{ROW_ACC, MODE_LOAD,   64'hFFFF_FFFF_FFFF_FFC0, CFG_SET_BITS,   5'd0,  1'b0, 4'b0000},
		// zero ways acts as one
		'{ROW_CFG, MODE_LOAD,   64'h0,                   CFG_WAYS_USED,  5'd0,  1'b0, 4'b0000},
		'{ROW_ACC, MODE_MODIFY, 64'h8000_0000_0000_0000, CFG_SET_BITS,   5'd0,  1'b0, 4'b0000},
		'{ROW_CFG, MODE_LOAD,   64'h0,                   CFG_WAYS_USED,  5'd12, 1'b0, 4'b0000},
		'{ROW_ACC, MODE_STORE,  64'h0123_4567_89AB_CDEF, CFG_SET_BITS,   5'd0,  1'b0, 4'b0000},
		'{ROW_ACC, MODE_LOAD,   64'h0123_4567_89AB_CDEF, CFG_SET_BITS,   5'd0,  1'b0, 4'b0000},
		// offset and index together wider than 32 bits
		'{ROW_CFG, MODE_LOAD,   64'h0,                   CFG_BLOCK_BITS, 5'd31, 1'b0, 4'b0000},
		'{ROW_ACC, MODE_LOAD,   64'hFFFF_FFFF_0000_0000, CFG_SET_BITS,   5'd0,  1'b0, 4'b0000},
		'{ROW_ACC, MODE_MODIFY, 64'h0000_00FF_8000_0000, CFG_SET_BITS,   5'd0,  1'b0, 4'b0000}
	};

	phase_t phases [PHASES] = '{
		'{5'd2,  5'd4,  5'd4,  8'd95,  7'd20, 7'd66, 1'b0},
		'{5'd1,  5'd0,  5'd2,  8'd90,  7'd20, 7'd66, 1'b0},
		'{5'd6,  5'd3,  5'd8,  8'd90,  7'd66, 7'd20, 1'b0},
		'{5'd31, 5'd31, 5'd31, 8'd90,  7'd66, 7'd20, 1'b0},
		'{5'd0,  5'd26, 5'd16, 8'd60,  7'd0,  7'd0,  1'b0},
		'{5'd3,  5'd12, 5'd9,  8'd100, 7'd0,  7'd0,  1'b1}
	};

	set_assoc_lru_cache_sim #(
		.MAX_SET_BITS(SET_BITS_CAP),
		.MAX_WAYS(WAY_CAP)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.acc_valid(acc_valid),
		.acc_stall(acc_stall),
		.acc(acc),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.res(res),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #5 clk = ~clk;

	function automatic logic [31:0] count_up_sat(input logic [31:0] v);
		return (v == '1) ? v : v + 32'd1;
	endfunction

	function automatic int unsigned eff_set_bits();
		return (geo_set_bits > SET_BITS_CAP) ? SET_BITS_CAP : geo_set_bits;
	endfunction

	function automatic int unsigned eff_ways();
		if (geo_ways == 0)
			return 1;
		return (geo_ways > WAY_CAP) ? WAY_CAP : geo_ways;
	endfunction

	// Look up one access in the bench cache, update it and return the result.
	function automatic res_t cache_access(input acc_t a);
		int unsigned sb, ways, set_idx, base, w, e, target, victim, empty_way;
		logic [63:0] tg;
		logic [31:0] oldest;
		bit found, has_empty;
		res_t r;
		r = '0;
		if (a.mode != MODE_IFETCH) begin
			sb = eff_set_bits();
			ways = eff_ways();
			set_idx = 32'((a.address >> geo_block_bits) & ((64'd1 << sb) - 64'd1));
			base = set_idx * WAY_CAP;
			tg = a.address >> (sb + geo_block_bits);
			found = 1'b0;
			has_empty = 1'b0;
			target = 0;
			victim = 0;
			empty_way = 0;
			oldest = stamp_mem[base];
			for (w = 0; w < ways; w++) begin
				e = base + w;
				// first way with the strictly smallest stamp wins
				if (stamp_mem[e] < oldest) begin
					oldest = stamp_mem[e];
					victim = w;
				end
				if (valid_mem[e] && tag_mem[e] == tg && !found) begin
					found = 1'b1;
					target = w;
				end
				if (!valid_mem[e] && !has_empty) begin
					has_empty = 1'b1;
					empty_way = w;
				end
			end
			if (found) begin
				r.hit = 1'b1;
				hits_pred = count_up_sat(hits_pred);
			end else begin
				r.miss = 1'b1;
				misses_pred = count_up_sat(misses_pred);
				if (has_empty) begin
					target = empty_way;
					valid_mem[base + target] = 1'b1;
				end else begin
					target = victim;
					r.eviction = 1'b1;
					evict_count = count_up_sat(evict_count);
				end
				tag_mem[base + target] = tg;
			end
			if (a.mode == MODE_MODIFY) begin
				r.extra_hit = 1'b1;
				hits_pred = count_up_sat(hits_pred);
			end
			stamp_mem[base + target] = use_clock;
			use_clock = use_clock + 32'd1;
		end
		r.hit_total = hits_pred;
		r.miss_total = misses_pred;
		r.eviction_total = evict_count;
		return r;
	endfunction

	task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
		if (got !== want) begin
			mismatch_count++;
			$display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
		end
	endtask

	// accept side: predict, and track register writes
	always @(posedge clk) begin : accept_mon
		res_t pred;
		row_mark_t mark;
		if (arst_n && acc_valid && !acc_stall) begin
			pred = cache_access(acc);
			mark = row_marks.pop_front();
			if (mark.typed)
				{pred.hit, pred.miss, pred.eviction, pred.extra_hit} = mark.flags;
			pending_results.push_back(pred);
			accesses_seen++;
		end
		if (arst_n && cfg_valid && cfg_ready) begin
			reg_writes++;
			case (cfg_index)
				CFG_SET_BITS: geo_set_bits = cfg_data[2:0];
				CFG_BLOCK_BITS: geo_block_bits = cfg_data[4:0];
				CFG_WAYS_USED: geo_ways = cfg_data[3:0];
				default: ;
			endcase
		end
	end

	// result side: compare against the oldest prediction
	always @(posedge clk) begin : result_mon
		res_t want;
		if (arst_n && res_valid && !res_stall) begin
			results_seen++;
			if (pending_results.size() == 0) begin
				mismatch_count++;
				$display("%0t: unexpected result, expected none, got %0h", $time, res);
			end else begin
				want = pending_results.pop_front();
				check_field("hit", want.hit, res.hit);
				check_field("miss", want.miss, res.miss);
				check_field("eviction", want.eviction, res.eviction);
				check_field("extra_hit", want.extra_hit, res.extra_hit);
				check_field("hit_total", want.hit_total, res.hit_total);
				check_field("miss_total", want.miss_total, res.miss_total);
				check_field("eviction_total", want.eviction_total, res.eviction_total);
			end
		end
	end

	// receiver: random stalls, plus a long hold-off on request
	always @(posedge clk) begin
		if (hold_served != hold_ticket) begin
			hold_served <= hold_ticket;
			hold_left <= HOLD_CYCLES;
			res_stall <= 1'b1;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			res_stall <= 1'b1;
		end else begin
			res_stall <= ($urandom_range(0, 99) < recv_stall_pct);
		end
	end

	always @(posedge clk) begin
		if (!arst_n)
			stuck_cycles <= 0;
		else if ((acc_valid && !acc_stall) || (res_valid && !res_stall) || (cfg_valid && cfg_ready))
			stuck_cycles <= 0;
		else
			stuck_cycles <= stuck_cycles + 1;
	end

	initial begin
		while (stuck_cycles < WATCHDOG_LIMIT)
			@(posedge clk);
		$display("%0t: watchdog, no transaction for %0d cycles", $time, WATCHDOG_LIMIT);
		$display("set_assoc_lru_cache_sim test failed");
		$finish;
	end

	// Keep valid high on return; the caller or the next call lowers it or replaces the access.
	task automatic send_access(input acc_t a, input row_mark_t m);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			acc_valid <= 1'b0;
			@(posedge clk);
		end
		row_marks.push_back(m);
		acc_valid <= 1'b1;
		acc <= a;
		do @(posedge clk); while (acc_stall !== 1'b0);
	endtask

	task automatic idle_acc();
		acc_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic drain();
		while (pending_results.size() != 0)
			@(posedge clk);
	endtask

	// Write one register with the cache idle.
	task automatic reconfigure(input logic [1:0] idx, input logic [4:0] val);
		idle_acc();
		drain();
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (cfg_ready !== 1'b1);
		cfg_valid <= 1'b0;
	endtask

	initial begin : stimulus
		acc_t a;
		phase_t ph;
		int unsigned sb, bb, ways, st;
		logic [63:0] tg;
		int n, p;

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table, reset geometry first
		send_idle_pct = 0;
		recv_stall_pct = 0;
		for (n = 0; n < DIR_ROWS; n++) begin
			if (dir_rows[n].kind == ROW_CFG) begin
				reconfigure(dir_rows[n].reg_idx, dir_rows[n].reg_val);
			end else begin
				a.mode = dir_rows[n].mode;
				a.address = dir_rows[n].address;
				send_access(a, '{dir_rows[n].typed, dir_rows[n].flags});
			end
		end

		for (p = 0; p < PHASES; p++) begin
			ph = phases[p];
			if (ph.pressure)
				reconfigure(CFG_NO_REG, 5'd21);
			reconfigure(CFG_SET_BITS, ph.sb_val);
			reconfigure(CFG_BLOCK_BITS, ph.bb_val);
			reconfigure(CFG_WAYS_USED, ph.ways_val);
			send_idle_pct = ph.send_pct;
			recv_stall_pct = ph.recv_pct;
			sb = eff_set_bits();
			bb = geo_block_bits;
			ways = eff_ways();
			for (n = 0; n < ph.items; n++) begin
				// back up the cache behind a long result hold-off
				if (ph.pressure && n == 20)
					hold_ticket++;
				// pause until every result is back
				if (ph.pressure && n == 60) begin
					idle_acc();
					drain();
				end
				a.mode = 2'($urandom_range(MODE_LOAD, MODE_IFETCH));
				if ($urandom_range(0, 99) < 15) begin
					a.address = {$urandom, $urandom};
				end else begin
					// small tag pool in a few sets so lines get reused
					tg = 64'($urandom_range(0, 2 * ways + 1));
					if ($urandom_range(0, 9) == 0)
						tg = tg | ({$urandom, $urandom} << 8);
					st = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 3);
					st = st & ((32'd1 << sb) - 32'd1);
					a.address = (tg << (sb + bb)) | (64'(st) << bb)
						| ({$urandom, $urandom} & ((64'd1 << bb) - 64'd1));
				end
				send_access(a, '0);
			end
		end

		idle_acc();
		drain();
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("covered %0d accesses over %0d geometries with %0d register writes,",
			accesses_seen, PHASES + 1, reg_writes);
		$display("including a long result hold-off and a full drain; %0d results compared",
			results_seen);
		if (mismatch_count == 0 && pending_results.size() == 0) begin
			$display("set_assoc_lru_cache_sim test passed");
		end else begin
			$display("%0d mismatches, %0d results outstanding", mismatch_count,
				pending_results.size());
			$display("set_assoc_lru_cache_sim test failed");
		end
		$finish;
	end

endmodule

>>> files.f
+incdir+hw/rtl
hw/rtl/slc_pkg.sv
hw/rtl/slc_lookup.sv
hw/rtl/set_assoc_lru_cache_sim.sv
hw/rtl/slc_checker.sv
tb/tb_set_assoc_lru_cache_sim.sv
